/* sv/gprcf_pkg.sv */
`default_nettype none
package gprcf_pkg;

    // APB register map: one 32-bit register every 4 bytes
    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic [0:0] REG_MOVE_THRESHOLD  = 1'd0;
    localparam logic [0:0] REG_THROTTLE_INTERVAL = 1'd1;

    localparam logic [7:0]  RST_MOVE_THRESHOLD    = 8'd8;
    localparam logic [31:0] RST_THROTTLE_INTERVAL = 32'd33000000;

    // Pad deflection limits used for the report mapping
    localparam logic signed [8:0] PAD_MIN = -9'sd160;
    localparam logic signed [8:0] PAD_MAX = 9'sd160;
    localparam logic [8:0]        PAD_OFS = 9'd160;

    typedef struct packed {
        logic [7:0]  move_threshold;
        logic [15:0] move_limit_sq;
        logic [31:0] throttle_interval;
    } t_cfg;

    typedef struct packed {
        logic [11:0]       button_bits;
        logic signed [8:0] pad_dx;
        logic signed [8:0] pad_dy;
        logic              touch_active;
        logic [8:0]        touch_x;
        logic [7:0]        touch_y;
        logic [63:0]       tick_now;
    } t_sample;

    typedef struct packed {
        logic [11:0] report_buttons;
        logic [15:0] pad_x_scaled;
        logic [15:0] pad_y_scaled;
        logic        report_touch_active;
        logic [8:0]  report_touch_x;
        logic [7:0]  report_touch_y;
    } t_report;

    // Map a saturated pad value v = d + 160 (0..320) to v * 32768 / 320.
    // v * 512 / 5 = v * 102 + floor(2v / 5); the last term uses 205/1024,
    // exact for 2v below 1024.
    function automatic logic [15:0] scale_pad(input logic signed [8:0] d);
        logic signed [8:0] s;
        logic [8:0]        v;
        logic [17:0]       q;
        s = d;
        if (d < PAD_MIN) s = PAD_MIN;
        if (d > PAD_MAX) s = PAD_MAX;
        v = $unsigned(s) + PAD_OFS;
        q = 18'({v, 1'b0}) * 18'd205;
        return 16'(16'(v) * 16'd102) + 16'(q[17:10]);
    endfunction

endpackage
`default_nettype wire

/* sv/gprcf_sample_if.sv */
`default_nettype none
interface gprcf_sample_if;
    logic              valid;
    logic              ready;
    logic [11:0]       button_bits;
    logic signed [8:0] pad_dx;
    logic signed [8:0] pad_dy;
    logic              touch_active;
    logic [8:0]        touch_x;
    logic [7:0]        touch_y;
    logic [63:0]       tick_now;

    modport source (
        output valid, button_bits, pad_dx, pad_dy, touch_active, touch_x, touch_y, tick_now,
        input  ready
    );
    modport sink (
        input  valid, button_bits, pad_dx, pad_dy, touch_active, touch_x, touch_y, tick_now,
        output ready
    );
endinterface
`default_nettype wire

/* sv/gprcf_report_if.sv */
`default_nettype none
interface gprcf_report_if;
    logic        valid;
    logic        ready;
    logic [11:0] report_buttons;
    logic [15:0] pad_x_scaled;
    logic [15:0] pad_y_scaled;
    logic        report_touch_active;
    logic [8:0]  report_touch_x;
    logic [7:0]  report_touch_y;

    modport source (
        output valid, report_buttons, pad_x_scaled, pad_y_scaled,
               report_touch_active, report_touch_x, report_touch_y,
        input  ready
    );
    modport sink (
        input  valid, report_buttons, pad_x_scaled, pad_y_scaled,
               report_touch_active, report_touch_x, report_touch_y,
        output ready
    );
endinterface
`default_nettype wire

/* sv/gprcf_cfg_regs.sv */
`default_nettype none
module gprcf_cfg_regs (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gprcf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [gprcf_pkg::DATA_W-1:0] pwdata,
    output logic      [gprcf_pkg::DATA_W-1:0] prdata,
    output logic                              pready,
    output gprcf_pkg::t_cfg                   o_cfg
);

    gprcf_pkg::t_cfg r_cfg;
    logic            wr_en;
    logic [0:0]      reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_sel = paddr[2:2];

    // Write registers; keep the squared threshold alongside the threshold
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.move_threshold    <= gprcf_pkg::RST_MOVE_THRESHOLD;
            r_cfg.move_limit_sq     <= 16'(gprcf_pkg::RST_MOVE_THRESHOLD)
                                       * 16'(gprcf_pkg::RST_MOVE_THRESHOLD);
            r_cfg.throttle_interval <= gprcf_pkg::RST_THROTTLE_INTERVAL;
        end else if (wr_en) begin
            unique case (reg_sel)
                gprcf_pkg::REG_MOVE_THRESHOLD: begin
                    r_cfg.move_threshold <= pwdata[7:0];
                    r_cfg.move_limit_sq  <= 16'(pwdata[7:0]) * 16'(pwdata[7:0]);
                end
                gprcf_pkg::REG_THROTTLE_INTERVAL: begin
                    r_cfg.throttle_interval <= pwdata;
                end
                default: begin
                end
            endcase
        end
    end

    // Read back
    always_comb begin
        unique case (reg_sel)
            gprcf_pkg::REG_MOVE_THRESHOLD:    prdata = {24'd0, r_cfg.move_threshold};
            gprcf_pkg::REG_THROTTLE_INTERVAL: prdata = r_cfg.throttle_interval;
            default:                          prdata = '0;
        endcase
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

/* sv/gamepad_report_change_filter_top.sv */
`default_nettype none
// Channel   Direction  Handshake      Payload
// i_sample  in         valid/ready    buttons, pad X/Y, touch flag, touch X/Y, tick
// o_report  out        valid/ready    buttons, scaled pad X/Y, touch flag, touch X/Y
// APB       in/out     psel/penable   move_threshold @0x0, throttle_interval @0x4
//
// One sample is accepted per cycle while i_sample.ready is high. Each sample is held in
// the input register, where the change and touch-movement decision is made against the
// stored sample; a report is loaded into the output register as the sample leaves the input register.
// i_sample.ready drops only when a sample that reports is held while a report
// waits unaccepted. Reset is synchronous and active low.
module gamepad_report_change_filter_top (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    gprcf_sample_if.sink                      i_sample,
    gprcf_report_if.source                    o_report,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gprcf_pkg::ADDR_W-1:0] paddr,
    input  wire logic [gprcf_pkg::DATA_W-1:0] pwdata,
    output logic      [gprcf_pkg::DATA_W-1:0] prdata,
    output logic                              pready
);

    gprcf_pkg::t_cfg    cfg;
    gprcf_pkg::t_sample r_in;
    logic               r_in_vld;
    gprcf_pkg::t_report r_out;
    gprcf_pkg::t_report n_out;
    logic               r_out_vld;

    // Stored reference sample
    logic [11:0]       r_prev_buttons;
    logic signed [8:0] r_prev_pad_dx;
    logic signed [8:0] r_prev_pad_dy;
    logic              r_prev_touch_active;
    logic [8:0]        r_prev_touch_x;
    logic [7:0]        r_prev_touch_y;
    logic [63:0]       r_last_touch_tick;

    logic               pad_btn_chg;
    logic               touch_chg;
    logic signed [9:0]  touch_dx;
    logic signed [8:0]  touch_dy;
    logic signed [19:0] dx_sq;
    logic signed [19:0] dy_sq;
    logic [19:0]        dist_sq;
    logic [63:0]        elapsed;
    logic               move_fire;
    logic               send;
    logic               advance;
    logic               in_ready;

    gprcf_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    // Decide whether the held sample reports
    always_comb begin
        pad_btn_chg = (r_in.button_bits != r_prev_buttons)
                   || (r_in.pad_dx != r_prev_pad_dx)
                   || (r_in.pad_dy != r_prev_pad_dy);
        touch_chg   = r_in.touch_active != r_prev_touch_active;
        touch_dx    = $signed({1'b0, r_in.touch_x}) - $signed({1'b0, r_prev_touch_x});
        touch_dy    = $signed({1'b0, r_in.touch_y}) - $signed({1'b0, r_prev_touch_y});
        dx_sq       = touch_dx * touch_dx;
        dy_sq       = touch_dy * touch_dy;
        dist_sq     = $unsigned(dx_sq) + $unsigned(dy_sq);
        elapsed     = r_in.tick_now - r_last_touch_tick;
        move_fire   = !touch_chg && r_in.touch_active
                   && (dist_sq > {4'd0, cfg.move_limit_sq})
                   && (elapsed > {32'd0, cfg.throttle_interval});
        send        = pad_btn_chg || touch_chg || move_fire;
    end

    // Advance unless a report must wait for the output slot
    assign advance  = r_in_vld && (!send || !r_out_vld || o_report.ready);
    assign in_ready = !r_in_vld || advance;
    assign i_sample.ready = in_ready;

    // Build the report payload
    always_comb begin
        n_out.report_buttons      = r_in.button_bits;
        n_out.pad_x_scaled        = gprcf_pkg::scale_pad(r_in.pad_dx);
        n_out.pad_y_scaled        = gprcf_pkg::scale_pad(r_in.pad_dy);
        n_out.report_touch_active = r_in.touch_active;
        n_out.report_touch_x      = r_in.touch_active ? r_in.touch_x : 9'd0;
        n_out.report_touch_y      = r_in.touch_active ? r_in.touch_y : 8'd0;
    end

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (in_ready) begin
            r_in_vld <= i_sample.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_ready && i_sample.valid) begin
            r_in.button_bits  <= i_sample.button_bits;
            r_in.pad_dx       <= i_sample.pad_dx;
            r_in.pad_dy       <= i_sample.pad_dy;
            r_in.touch_active <= i_sample.touch_active;
            r_in.touch_x      <= i_sample.touch_x;
            r_in.touch_y      <= i_sample.touch_y;
            r_in.tick_now     <= i_sample.tick_now;
        end
    end

    // Update the reference on each report; refresh touch time on movement only
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons      <= '0;
            r_prev_pad_dx       <= '0;
            r_prev_pad_dy       <= '0;
            r_prev_touch_active <= 1'b0;
            r_prev_touch_x      <= '0;
            r_prev_touch_y      <= '0;
            r_last_touch_tick   <= '0;
        end else if (advance && send) begin
            r_prev_buttons      <= r_in.button_bits;
            r_prev_pad_dx       <= r_in.pad_dx;
            r_prev_pad_dy       <= r_in.pad_dy;
            r_prev_touch_active <= r_in.touch_active;
            r_prev_touch_x      <= r_in.touch_x;
            r_prev_touch_y      <= r_in.touch_y;
            if (move_fire) begin
                r_last_touch_tick <= r_in.tick_now;
            end
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (advance && send) begin
            r_out_vld <= 1'b1;
        end else if (o_report.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && send) begin
            r_out <= n_out;
        end
    end

    assign o_report.valid               = r_out_vld;
    assign o_report.report_buttons      = r_out.report_buttons;
    assign o_report.pad_x_scaled        = r_out.pad_x_scaled;
    assign o_report.pad_y_scaled        = r_out.pad_y_scaled;
    assign o_report.report_touch_active = r_out.report_touch_active;
    assign o_report.report_touch_x      = r_out.report_touch_x;
    assign o_report.report_touch_y      = r_out.report_touch_y;

endmodule
`default_nettype wire
